// ===== hw/rtl/mclbc_pkg.sv =====
`timescale 1ns / 1ps

package mclbc_pkg;

	// Register widths of the three generators
	localparam int unsigned ShortW  = 19;
	localparam int unsigned MiddleW = 22;
	localparam int unsigned LongW   = 23;
	localparam int unsigned KeyW    = ShortW + MiddleW + LongW;
	localparam int unsigned ByteW   = 8;

	// Clocking tap positions
	localparam int unsigned ShortClk  = 8;
	localparam int unsigned MiddleClk = 10;
	localparam int unsigned LongClk   = 10;

	// Generator state; the short register sits in the top bits, like the key
	typedef struct packed {
		logic [ShortW-1:0]  r_short;
		logic [MiddleW-1:0] r_middle;
		logic [LongW-1:0]   r_long;
	} lfsr_state_t;

	// Split the key: 63..45 short, 44..23 middle, 22..0 long
	function automatic lfsr_state_t load_key(input logic [KeyW-1:0] key);
		lfsr_state_t s;
		s.r_short  = key[KeyW-1 -: ShortW];
		s.r_middle = key[LongW +: MiddleW];
		s.r_long   = key[LongW-1:0];
		return s;
	endfunction

	// One majority-clocked step; feedback taps are read before the shift
	function automatic lfsr_state_t clock_once(input lfsr_state_t s);
		lfsr_state_t n;
		logic cs;
		logic cm;
		logic cl;
		logic maj;
		n   = s;
		cs  = s.r_short[ShortClk];
		cm  = s.r_middle[MiddleClk];
		cl  = s.r_long[LongClk];
		maj = (cs & cm) | (cs & cl) | (cm & cl);
		if (cs == maj) begin
			n.r_short = {s.r_short[ShortW-2:0],
				s.r_short[18] ^ s.r_short[17] ^ s.r_short[16] ^ s.r_short[13]};
		end
		if (cm == maj) begin
			n.r_middle = {s.r_middle[MiddleW-2:0], s.r_middle[21] ^ s.r_middle[20]};
		end
		if (cl == maj) begin
			n.r_long = {s.r_long[LongW-2:0],
				s.r_long[22] ^ s.r_long[21] ^ s.r_long[20] ^ s.r_long[7]};
		end
		return n;
	endfunction

	// Keystream bit: XOR of the three MSBs
	function automatic logic ks_bit(input lfsr_state_t s);
		return s.r_short[ShortW-1] ^ s.r_middle[MiddleW-1] ^ s.r_long[LongW-1];
	endfunction

endpackage

// ===== hw/rtl/mclbc_keystream.sv =====
`timescale 1ns / 1ps

module mclbc_keystream (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic                      restart,
	input  logic [mclbc_pkg::KeyW-1:0] key,
	output logic [mclbc_pkg::ByteW-1:0] ks_byte
);
	import mclbc_pkg::*;

	lfsr_state_t lfsr_q;
	lfsr_state_t lfsr_next;

	// Run the eight steps of one byte, first keystream bit into the MSB
	always_comb begin
		lfsr_state_t st;
		st = restart ? load_key(key) : lfsr_q;
		ks_byte = '0;
		for (int i = 0; i < ByteW; i++) begin
			st = clock_once(st);
			ks_byte[3'(ByteW - 1 - i)] = ks_bit(st);
		end
		lfsr_next = st;
	end

	// Advance the generators once per byte transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= '0;
		end else if (advance) begin
			lfsr_q <= lfsr_next;
		end
	end

	// Generators hold between bytes
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(lfsr_q))
		else $error("generator state moved without a byte");

	// An all-zero state is a fixed point without restart
	a_zero_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !restart && lfsr_q == '0) |=> lfsr_q == '0)
		else $error("zero state left without restart");

	// An all-zero state gives an all-zero keystream
	a_zero_ks: assert property (@(posedge clk) disable iff (!arst_n)
		(!restart && lfsr_q == '0) |-> ks_byte == '0)
		else $error("nonzero keystream from zero state");

endmodule

// ===== hw/rtl/majority_clocked_lfsr_byte_cipher_top.sv =====
`timescale 1ns / 1ps

// Byte stream cipher with three majority-clocked LFSRs (19, 22, 23 bits).
// Input stream: s_axis_tdata carries the data byte, s_axis_tuser the restart
// flag; a byte with restart set reloads the generators from the key first.
// Output stream: m_axis_tdata carries the byte XOR eight keystream bits,
// the first keystream bit in bit 7.
// Key: cfg_we writes cfg_wdata into the key register; bits 63..45 load the
// short register, 44..23 the middle and 22..0 the long one. Write it only
// while no byte is in flight.
// Each byte passes the input register and then the output register: the
// input register takes the byte, then the eight generator steps run in one
// combinational pass into the output register. Throughput is one byte per
// cycle while the receiver does not stall.
// Reset clears the key and the generators; before the first restart the
// keystream is zero and bytes pass unchanged.
// When the receiver stalls the output register holds, the input register
// fills, and s_axis_tready drops until the output is taken.
module majority_clocked_lfsr_byte_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] cipher_byte
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	import mclbc_pkg::*;

	logic [KeyW-1:0]  key_q;
	logic             valid_s1;
	logic [ByteW-1:0] data_s1;
	logic             restart_s1;
	logic             out_valid_q;
	logic [ByteW-1:0] out_data_q;
	logic [ByteW-1:0] ks_byte;
	logic             advance;

	// Move stage 1 on when the output register is free or being taken
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1    <= s_axis_tdata;
			restart_s1 <= s_axis_tuser;
		end
	end

	mclbc_keystream u_keystream (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.restart (restart_s1),
		.key     (key_q),
		.ks_byte (ks_byte)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= data_s1 ^ ks_byte;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
